// File: src/atan2ra_pkg.sv
// ----------------------------------------------------------------------------
// atan2ra_pkg
// Shared widths, constants and types for the rational atan2 approximation.
// ----------------------------------------------------------------------------
package atan2ra_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 13;

  localparam int unsigned IN_W    = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned PROD_W  = 2 * MAG_W;
  // 25*big^2 + 7*small^2 reaches 2^35 when both magnitudes are 2^15
  localparam int unsigned DIV_W   = 36;

  // pi * 2^29, rounded
  localparam logic [63:0] PI_Q29 = 64'd1686629713;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sh7fff;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 16'sh8000;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic swap;
  } ctl_t;

endpackage

// File: src/atan2ra_if.sv
// ----------------------------------------------------------------------------
// atan2ra_in_if / atan2ra_out_if
// Valid/ready channels carrying the (y, x) request and the angle result.
// ----------------------------------------------------------------------------
interface atan2ra_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [atan2ra_pkg::IN_W-1:0]    y_value;
  logic signed [atan2ra_pkg::IN_W-1:0]    x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface atan2ra_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [atan2ra_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// File: src/atan2ra_div.sv
// ----------------------------------------------------------------------------
// atan2ra_div
// Pipelined restoring divider, one quotient bit per stage, for num < den.
// ----------------------------------------------------------------------------
module atan2ra_div #(
  parameter int unsigned QW = atan2ra_pkg::ANGLE_FRAC_BITS_DEF + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [atan2ra_pkg::DIV_W-1:0]   num_i,
  input  logic [atan2ra_pkg::DIV_W-1:0]   den_i,
  input  atan2ra_pkg::ctl_t               ctl_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [QW-1:0]                   quo_o,
  output atan2ra_pkg::ctl_t               ctl_o
);

  localparam int unsigned DW = atan2ra_pkg::DIV_W;

  logic                  v_q   [QW];
  logic [DW-1:0]         rem_q [QW];
  logic [DW-1:0]         den_q [QW];
  logic [QW-1:0]         quo_q [QW];
  atan2ra_pkg::ctl_t     ctl_q [QW];
  logic [QW:0]           rdy;

  assign rdy[QW]    = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [DW-1:0]     den_in;
    logic [QW-1:0]     quo_in;
    atan2ra_pkg::ctl_t ctl_in;
    logic [DW:0]       dbl;
    logic [DW:0]       diff;
    logic              take;
    logic [DW-1:0]     rem_d;
    logic [QW-1:0]     quo_d;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_comb begin
      dbl   = {rem_in, 1'b0};
      diff  = dbl - {1'b0, den_in};
      take  = (dbl >= {1'b0, den_in});
      rem_d = take ? diff[DW-1:0] : dbl[DW-1:0];
      quo_d = {quo_in[QW-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  assign out_valid_o = v_q[QW-1];
  assign quo_o       = quo_q[QW-1];
  assign ctl_o       = ctl_q[QW-1];

endmodule

// File: src/atan2_rational_approx.sv
// The block returns atan2(y, x) in radians with ANGLE_FRAC_BITS fractional bits for each
// signed 16-bit (y, x) request, using the 0.28 rational approximation with 0.28 taken as
// 7/25. It takes one request every clock while the pipe is not stalled and returns one
// result per request, in order. Registers hold magnitude select, the products and the
// constant-weighted sums in turn; the restoring divider then produces one quotient bit per
// stage, and a last register holds rounding, quadrant offset and saturation. Each stage
// holds its item while the next one cannot take it, so a stalled result register lets
// the pipe keep filling.
// ----------------------------------------------------------------------------
// atan2_rational_approx
// Fixed-point four-quadrant arctangent, fully pipelined.
// ----------------------------------------------------------------------------
module atan2_rational_approx #(
  parameter int unsigned ANGLE_FRAC_BITS = atan2ra_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  atan2ra_in_if.sink           req_i,
  atan2ra_out_if.source        res_o
);

  localparam int unsigned F     = ANGLE_FRAC_BITS;
  localparam int unsigned QW    = F + 1;
  localparam int unsigned RW    = (F + 4 > 17) ? F + 4 : 17;
  localparam int unsigned MW    = atan2ra_pkg::MAG_W;
  localparam int unsigned PW    = atan2ra_pkg::PROD_W;
  localparam int unsigned DW    = atan2ra_pkg::DIV_W;
  localparam int unsigned AW    = atan2ra_pkg::ANGLE_W;

  localparam logic [63:0] PI_FULL  =
    (atan2ra_pkg::PI_Q29 + (64'd1 << (28 - F))) >> (29 - F);
  localparam logic [63:0] HPI_FULL =
    (atan2ra_pkg::PI_Q29 + (64'd1 << (29 - F))) >> (30 - F);
  localparam logic signed [RW-1:0] PI_FIX  = PI_FULL[RW-1:0];
  localparam logic signed [RW-1:0] HPI_FIX = HPI_FULL[RW-1:0];
  localparam logic signed [RW-1:0] SAT_HI  = RW'(atan2ra_pkg::ANGLE_MAX);
  localparam logic signed [RW-1:0] SAT_LO  = RW'(atan2ra_pkg::ANGLE_MIN);
  localparam logic [QW-1:0]        RATIO_MAX = QW'(((64'd25 << F) >> 5) + 64'd1);

  // stage 1: magnitudes and ordering
  logic              v1_q, v2_q, v3_q;
  logic              r1, r2, r3;
  logic [MW-1:0]     big_q, small_q;
  atan2ra_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic [MW-1:0]     ax, ay;
  atan2ra_pkg::ctl_t ctl1_d;

  // stage 2: products
  logic [PW-1:0]     bb_q, ss_q, bs_q;

  // stage 3: numerator and denominator
  logic [DW-1:0]     num_q, den_q;

  // divider
  logic              div_in_ready;
  logic              div_valid;
  logic [QW-1:0]     div_quo;
  atan2ra_pkg::ctl_t div_ctl;

  // output stage
  logic              out_valid_q;
  logic [AW-1:0]     angle_q;
  logic              out_rdy;
  logic [QW:0]       qinc;
  logic [QW-1:0]     qmag;
  logic signed [RW-1:0] r_pos, r_sgn, res;
  logic [AW-1:0]     angle_d;

  function automatic int unsigned IN_MSB();
    return atan2ra_pkg::IN_W - 1;
  endfunction

  assign out_rdy     = !out_valid_q || res_o.ready;
  assign r3          = !v3_q || div_in_ready;
  assign r2          = !v2_q || r3;
  assign r1          = !v1_q || r2;
  assign req_i.ready = r1;

  always_comb begin
    ax = req_i.x_value[IN_MSB()] ? MW'(-req_i.x_value) : MW'(req_i.x_value);
    ay = req_i.y_value[IN_MSB()] ? MW'(-req_i.y_value) : MW'(req_i.y_value);
    ctl1_d.x_zero = (req_i.x_value == '0);
    ctl1_d.y_zero = (req_i.y_value == '0);
    ctl1_d.x_neg  = req_i.x_value[IN_MSB()];
    ctl1_d.y_neg  = req_i.y_value[IN_MSB()];
    ctl1_d.swap   = (ay >= ax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= req_i.valid;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && req_i.valid) begin
      big_q   <= ctl1_d.swap ? ay : ax;
      small_q <= ctl1_d.swap ? ax : ay;
      ctl1_q  <= ctl1_d;
    end
    if (r2 && v1_q) begin
      bb_q   <= big_q * big_q;
      ss_q   <= small_q * small_q;
      bs_q   <= big_q * small_q;
      ctl2_q <= ctl1_q;
    end
    if (r3 && v2_q) begin
      den_q  <= (DW'(bb_q) << 4) + (DW'(bb_q) << 3) + DW'(bb_q)
              + (DW'(ss_q) << 2) + (DW'(ss_q) << 1) + DW'(ss_q);
      num_q  <= (DW'(bs_q) << 4) + (DW'(bs_q) << 3) + DW'(bs_q);
      ctl3_q <= ctl2_q;
    end
  end

  atan2ra_div #(
    .QW (QW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (div_in_ready),
    .num_i       (num_q),
    .den_i       (den_q),
    .ctl_i       (ctl3_q),
    .out_valid_o (div_valid),
    .out_ready_i (out_rdy),
    .quo_o       (div_quo),
    .ctl_o       (div_ctl)
  );

  always_comb begin
    qinc  = {1'b0, div_quo} + (QW + 1)'(1);
    qmag  = qinc[QW:1];
    r_pos = RW'(qmag);
    r_sgn = (div_ctl.x_neg ^ div_ctl.y_neg) ? -r_pos : r_pos;
    if (div_ctl.x_zero) begin
      if (div_ctl.y_zero) begin
        res = '0;
      end else if (div_ctl.y_neg) begin
        res = -HPI_FIX;
      end else begin
        res = HPI_FIX;
      end
    end else if (!div_ctl.swap) begin
      if (!div_ctl.x_neg) begin
        res = r_sgn;
      end else if (div_ctl.y_neg) begin
        res = r_sgn - PI_FIX;
      end else begin
        res = r_sgn + PI_FIX;
      end
    end else begin
      res = div_ctl.y_neg ? (HPI_FIX - r_sgn - PI_FIX) : (HPI_FIX - r_sgn);
    end
    if (res > SAT_HI) begin
      angle_d = atan2ra_pkg::ANGLE_MAX;
    end else if (res < SAT_LO) begin
      angle_d = atan2ra_pkg::ANGLE_MIN;
    end else begin
      angle_d = res[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_valid) begin
      angle_q <= angle_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.angle = angle_q;

`ifndef SYNTHESIS
  // any backpressure on the request side comes from a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> out_valid_q)
    else $error("request stalled with empty result register");

  // the rational term never exceeds 25/32 of a radian by more than one LSB of rounding
  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && !div_ctl.x_zero) |-> (qmag <= RATIO_MAX))
    else $error("ratio term out of range");

  // a delivered angle stays within plus or minus pi when pi fits the output
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (PI_FIX <= SAT_HI)) |->
      (($signed(RW'($signed(angle_q))) <= PI_FIX) &&
       ($signed(RW'($signed(angle_q))) >= -PI_FIX)))
    else $error("angle outside minus pi to pi");

  // a held result keeps its value until taken
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> $stable(angle_q))
    else $error("held result changed");
`endif

endmodule

// File: test/atan2_rational_approx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_rational_approx_checker
// Watches the request and result channels of the arctangent block, works out
// the angle due for every accepted (y, x) request with its own fixed-point
// model of the 7/25 rational approximation, and compares every accepted
// result in order against it. Counts failures for the testbench top.
// ----------------------------------------------------------------------------
module atan2_rational_approx_checker #(
  parameter int unsigned FRAC = atan2ra_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  atan2ra_in_if  req_mon,
  atan2ra_out_if res_mon,
  output int     failures_o,
  output int     pending_o
);
  import atan2ra_pkg::*;

  logic signed [ANGLE_W-1:0] expected_angles [$];

  function automatic logic signed [ANGLE_W-1:0] predict_angle(
    input logic signed [IN_W-1:0] y,
    input logic signed [IN_W-1:0] x
  );
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned den;
    longint unsigned mag;
    longint          pi_q;
    longint          hpi_q;
    longint          ratio;
    longint          ang;
    pi_q  = longint'((PI_Q29 + (64'd1 << (28 - FRAC))) >> (29 - FRAC));
    hpi_q = longint'((PI_Q29 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    if (x == 0) begin
      if (y > 0) ang = hpi_q;
      else if (y == 0) ang = 0;
      else ang = -hpi_q;
    end else begin
      ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
      ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
      if (ay < ax) den = 64'd25 * ax * ax + 64'd7 * ay * ay;
      else den = 64'd25 * ay * ay + 64'd7 * ax * ax;
      // exact quotient scaled to the angle format, halves away from zero
      mag = (64'd25 * ax * ay) << FRAC;
      mag = (64'd2 * mag + den) / (64'd2 * den);
      ratio = ((x < 0) != (y < 0)) ? -longint'(mag) : longint'(mag);
      if (ay < ax) begin
        ang = ratio;
        if (x < 0) ang = (y < 0) ? ang - pi_q : ang + pi_q;
      end else begin
        ang = hpi_q - ratio;
        if (y < 0) ang = ang - pi_q;
      end
    end
    if (ang > 32767) return ANGLE_MAX;
    if (ang < -32768) return ANGLE_MIN;
    return ang[ANGLE_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    logic signed [ANGLE_W-1:0] want;
    if (rst_ni) begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected result: angle %0d with no request outstanding", res_mon.angle);
          failures_o <= failures_o + 1;
        end else begin
          want = expected_angles.pop_front();
          if (res_mon.angle !== want) begin
            $error("angle mismatch: expected %0d, actual %0d", want, res_mon.angle);
            failures_o <= failures_o + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_angles.push_back(predict_angle(req_mon.y_value, req_mon.x_value));
    end else begin
      failures_o <= 0;
    end
    pending_o <= expected_angles.size();
  end

endmodule

// File: test/tb_atan2_rational_approx.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atan2_rational_approx
// Drives (y, x) requests into the arctangent block: axis, corner, equal
// magnitude and quadrant cases first, then random vectors in three phases:
// sender idling and receiver stalls in two, neither in the last. A checker
// by the block predicts and compares every angle; the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_atan2_rational_approx;
  import atan2ra_pkg::*;

  localparam int unsigned FRAC        = ANGLE_FRAC_BITS_DEF;
  localparam int          PHASE_REQS  = 175;
  localparam int          NUM_DIRECT  = 24;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          failures;
  int          pending;

  int dir_y [NUM_DIRECT] = '{0, 1, -1, 32767, -32768, 0, 0, 0, 0, -32768, 32767, -32768,
                             32767, 100, -100, 100, -100, 3, 3, -3, -3, -1, 1, 5};
  int dir_x [NUM_DIRECT] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, -32768, 32767, 32767,
                             -32768, 100, 100, -100, -100, 5, -5, -5, 5, -32768, -32768, 3};
  int corners [5] = '{-32768, -1, 0, 1, 32767};

  atan2ra_in_if  req_if ();
  atan2ra_out_if res_if ();

  atan2_rational_approx #(
    .ANGLE_FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  atan2_rational_approx_checker #(
    .FRAC (FRAC)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .res_mon    (res_if),
    .failures_o (failures),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_req(input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.y_value <= y;
    req_if.x_value <= x;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // hold off until every outstanding request has its angle back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int                       mode;
    logic signed [IN_W-1:0]   ry;
    logic signed [IN_W-1:0]   rx;
    rst_ni          = 1'b0;
    send_idle_pct   = 30;
    recv_stall_pct  = 56;
    req_if.valid   <= 1'b0;
    req_if.y_value <= '0;
    req_if.x_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECT; i++) send_req(IN_W'(dir_y[i]), IN_W'(dir_x[i]));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 30;
          recv_stall_pct = 56;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 30;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (i == PHASE_REQS / 2) drain();
        mode = $urandom_range(0, 9);
        ry   = IN_W'($urandom);
        rx   = IN_W'($urandom);
        case (mode)
          4: begin
            ry = IN_W'($urandom_range(0, 128)) - 16'sd64;
            rx = IN_W'($urandom_range(0, 128)) - 16'sd64;
          end
          5: begin
            rx = $urandom_range(1) ? ry : -ry;
          end
          6: begin
            if ($urandom_range(1)) ry = '0;
            else rx = '0;
          end
          7: begin
            ry = IN_W'(corners[$urandom_range(0, 4)]);
            rx = IN_W'(corners[$urandom_range(0, 4)]);
          end
          8: begin
            rx = ry + IN_W'($urandom_range(0, 6)) - 16'sd3;
          end
          9: begin
            rx = -16'sd32768 + IN_W'($urandom_range(0, 255));
            ry = IN_W'($urandom_range(0, 16)) - 16'sd8;
          end
          default: begin
          end
        endcase
        send_req(ry, rx);
      end
    end

    drain();
    repeat (FRAC + 20) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: atan2_rational_approx.f
src/atan2ra_pkg.sv
src/atan2ra_if.sv
src/atan2ra_div.sv
src/atan2_rational_approx.sv
test/atan2_rational_approx_checker.sv
test/tb_atan2_rational_approx.sv
